@@ design/ffra_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared widths, codes and controller/datapath interface types for the
// first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int IDX_W  = 14;
  localparam int CNT_W  = 11;
  localparam int OFS_W  = 10;
  localparam int LEN_W  = 11;
  localparam int HS_W   = 11;
  localparam int ST_W   = 2;

  localparam int MAX_PAGE_SLOTS = 1024;
  localparam logic [HS_W-1:0] HS_RESET = 11'd256;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_PAGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_COUNT  = 2'd2;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 2'd3;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Register index as seen on address bit 2.
  localparam logic REG_PAGE_SIZE = 1'b0;

  typedef struct packed {
    logic            start;
    logic            out_load;
    logic            walk_init;
    logic            walk_step;
    logic            rd_cur;
    logic            rd_nb;
    logic            mul_cur;
    logic            mul_open;
    logic            idx_load;
    logic            idx_ofs;
    logic            trim;
    logic            grow_front;
    logic            wr_len;
    logic            newlen_init;
    logic            newlen_add;
    logic            take;
    logic            take_before;
    logic            link_last;
    logic            link_before;
    logic            unlink;
    logic            unlink_nb;
    logic            open_page;
    logic            div_start;
    logic            st_wr;
    logic [ST_W-1:0] st_val;
  } ffra_cmd_t;

  typedef struct packed {
    logic is_release;
    logic bad_cnt;
    logic walk_ok;
    logic c_fits;
    logic c_exact;
    logic pages_full;
    logic need_entry;
    logic spare;
    logic div_done;
    logic page_bad;
    logic stop_bad;
    logic same_pg;
    logic adj_after;
    logic stop_eq;
    logic stop_lt;
    logic n_valid;
    logic n_merge;
  } ffra_sts_t;

endpackage
`default_nettype wire

@@ design/ffra_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_div
// Restoring divider, one quotient bit per cycle; splits a global slot index
// into page and offset.
// ----------------------------------------------------------------------------
module ffra_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ffra_pkg::IDX_W-1:0] dividend,
  input  wire logic [ffra_pkg::HS_W-1:0]  divisor,
  output logic      [ffra_pkg::IDX_W-1:0] quot,
  output logic      [ffra_pkg::HS_W-1:0]  rem,
  output logic                            done
);

  localparam int CW = $clog2(ffra_pkg::IDX_W + 1);

  logic [ffra_pkg::IDX_W-1:0] dvd;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [ffra_pkg::HS_W:0]    trial;
  logic                       ge;

  assign trial = {rem, dvd[ffra_pkg::IDX_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(ffra_pkg::IDX_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= {dvd[ffra_pkg::IDX_W-2:0], 1'b0};
      quot <= {quot[ffra_pkg::IDX_W-2:0], ge};
      if (ge) begin
        rem <= ffra_pkg::HS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= ffra_pkg::HS_W'(trial);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ffra_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_datapath
// Range table memories, list pointers, spare entry stack, page counter and
// the arithmetic that the controller sequences.
// ----------------------------------------------------------------------------
module ffra_datapath #(
  parameter int MAX_PAGES  = 16,
  parameter int MAX_RANGES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ffra_pkg::ffra_cmd_t        cmd,
  output ffra_pkg::ffra_sts_t             sts,
  input  wire logic [ffra_pkg::HS_W-1:0]  hs_eff,
  input  wire logic                       kind,
  input  wire logic [ffra_pkg::CNT_W-1:0] req_count,
  input  wire logic [ffra_pkg::IDX_W-1:0] req_index,
  output logic      [ffra_pkg::IDX_W-1:0] handle_index,
  output logic      [ffra_pkg::CNT_W-1:0] handle_count,
  output logic      [ffra_pkg::ST_W-1:0]  status
);

  localparam int EW    = $clog2(MAX_RANGES);
  localparam int PTRW  = $clog2(MAX_RANGES + 1);
  localparam int PGW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int POW   = $clog2(MAX_PAGES + 1);
  localparam int PRODW = PGW + ffra_pkg::HS_W;
  localparam int SW    = ffra_pkg::HS_W + 1;
  localparam logic [PTRW-1:0] NIL = PTRW'(MAX_RANGES);

  typedef struct packed {
    logic [PGW-1:0]             pg;
    logic [ffra_pkg::OFS_W-1:0] ofs;
    logic [ffra_pkg::LEN_W-1:0] len;
  } rng_t;

  rng_t            dmem [MAX_RANGES];
  logic [PTRW-1:0] nmem [MAX_RANGES];
  logic [PTRW-1:0] pmem [MAX_RANGES];
  logic [EW-1:0]   smem [MAX_RANGES];

  logic                       kind_q;
  logic [ffra_pkg::CNT_W-1:0] cnt_q;
  logic [ffra_pkg::IDX_W-1:0] idx_q;
  logic [ffra_pkg::HS_W-1:0]  hs_q;
  logic [PTRW-1:0]            e_q, steps_q, ne_q;
  logic [PTRW-1:0]            head_q, tail_q, fresh_q, rc_q;
  logic [POW-1:0]             pages_open_q;
  rng_t                       c_d, n_d;
  logic [PTRW-1:0]            c_nxt, c_prv, n_nxt, n_prv;
  logic [ffra_pkg::LEN_W-1:0] newlen_q;
  logic [PRODW-1:0]           prod_q;
  logic [ffra_pkg::IDX_W-1:0] res_index_q;
  logic [ffra_pkg::ST_W-1:0]  res_st_q;
  logic [EW-1:0]              s_top;

  logic [ffra_pkg::IDX_W-1:0] page;
  logic [ffra_pkg::HS_W-1:0]  begin_ofs;
  logic                       div_done;
  logic [SW-1:0]              stop;
  logic [EW-1:0]              rd_addr;
  logic [PTRW-1:0]            rc_dec;
  logic [PTRW-1:0]            ne_sel;
  rng_t                       new_d;
  logic [PTRW-1:0]            v_idx, v_nxt, v_prv;

  logic                       d_we;
  logic [EW-1:0]              d_wa;
  rng_t                       d_wd;
  logic                       n_we, p_we, s_we;
  logic [EW-1:0]              n_wa, p_wa, s_wa;
  logic [PTRW-1:0]            n_wd, p_wd;

  ffra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (idx_q),
    .divisor  (hs_q),
    .quot     (page),
    .rem      (begin_ofs),
    .done     (div_done)
  );

  assign stop    = {1'b0, begin_ofs} + SW'(cnt_q);
  assign rd_addr = cmd.rd_nb ? c_nxt[EW-1:0] : e_q[EW-1:0];
  assign rc_dec  = rc_q - 1'b1;
  assign ne_sel  = (rc_q != '0) ? PTRW'(s_top) : fresh_q;
  assign v_idx   = cmd.unlink_nb ? c_nxt : e_q;
  assign v_nxt   = cmd.unlink_nb ? n_nxt : c_nxt;
  assign v_prv   = cmd.unlink_nb ? n_prv : c_prv;

  always_comb begin
    if (kind_q == ffra_pkg::KIND_ALLOC) begin
      new_d.pg  = pages_open_q[PGW-1:0];
      new_d.ofs = cnt_q[ffra_pkg::OFS_W-1:0];
      new_d.len = ffra_pkg::LEN_W'(hs_q - cnt_q);
    end else begin
      new_d.pg  = page[PGW-1:0];
      new_d.ofs = begin_ofs[ffra_pkg::OFS_W-1:0];
      new_d.len = cnt_q;
    end
  end

  // Write port selection; the controller never issues two writers of the
  // same memory in one cycle.
  always_comb begin
    d_we = 1'b0;
    d_wa = e_q[EW-1:0];
    d_wd = c_d;
    n_we = 1'b0;
    n_wa = ne_sel[EW-1:0];
    n_wd = NIL;
    p_we = 1'b0;
    p_wa = ne_sel[EW-1:0];
    p_wd = tail_q;
    s_we = 1'b0;
    s_wa = rc_q[EW-1:0];
    if (cmd.take) begin
      d_we = 1'b1;
      d_wa = ne_sel[EW-1:0];
      d_wd = new_d;
      n_we = 1'b1;
      n_wd = cmd.take_before ? e_q : NIL;
      p_we = 1'b1;
      p_wd = cmd.take_before ? c_prv : tail_q;
    end
    if (cmd.trim) begin
      d_we     = 1'b1;
      d_wd.ofs = c_d.ofs + ffra_pkg::OFS_W'(cnt_q);
      d_wd.len = c_d.len - cnt_q;
    end
    if (cmd.grow_front) begin
      d_we     = 1'b1;
      d_wd.ofs = begin_ofs[ffra_pkg::OFS_W-1:0];
      d_wd.len = c_d.len + cnt_q;
    end
    if (cmd.wr_len) begin
      d_we     = 1'b1;
      d_wd.len = newlen_q;
    end
    if (cmd.link_last) begin
      n_we = tail_q < NIL;
      n_wa = tail_q[EW-1:0];
      n_wd = ne_q;
    end
    if (cmd.link_before) begin
      n_we = c_prv < NIL;
      n_wa = c_prv[EW-1:0];
      n_wd = ne_q;
      p_we = 1'b1;
      p_wa = e_q[EW-1:0];
      p_wd = ne_q;
    end
    if (cmd.unlink) begin
      n_we = v_prv < NIL;
      n_wa = v_prv[EW-1:0];
      n_wd = v_nxt;
      p_we = v_nxt < NIL;
      p_wa = v_nxt[EW-1:0];
      p_wd = v_prv;
      s_we = rc_q < NIL;
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_wa] <= d_wd;
    end
    if (n_we) begin
      nmem[n_wa] <= n_wd;
    end
    if (p_we) begin
      pmem[p_wa] <= p_wd;
    end
    if (s_we) begin
      smem[s_wa] <= v_idx[EW-1:0];
    end
    s_top <= smem[rc_dec[EW-1:0]];
    if (cmd.rd_cur) begin
      c_d   <= dmem[rd_addr];
      c_nxt <= nmem[rd_addr];
      c_prv <= pmem[rd_addr];
    end
    if (cmd.rd_nb) begin
      n_d   <= dmem[rd_addr];
      n_nxt <= nmem[rd_addr];
      n_prv <= pmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_q   <= kind;
      cnt_q    <= req_count;
      idx_q    <= req_index;
      hs_q     <= hs_eff;
      res_st_q <= ffra_pkg::ST_OK;
    end
    if (cmd.st_wr) begin
      res_st_q <= cmd.st_val;
    end
    if (cmd.walk_init) begin
      e_q     <= head_q;
      steps_q <= '0;
    end
    if (cmd.walk_step) begin
      e_q     <= c_nxt;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd.mul_cur) begin
      prod_q <= PRODW'(c_d.pg) * PRODW'(hs_q);
    end
    if (cmd.mul_open) begin
      prod_q <= PRODW'(pages_open_q[PGW-1:0]) * PRODW'(hs_q);
    end
    if (cmd.idx_load) begin
      if (cmd.idx_ofs) begin
        res_index_q <= ffra_pkg::IDX_W'(prod_q + PRODW'(c_d.ofs));
      end else begin
        res_index_q <= ffra_pkg::IDX_W'(prod_q);
      end
    end
    if (cmd.newlen_init) begin
      newlen_q <= c_d.len + cnt_q;
    end
    if (cmd.newlen_add) begin
      newlen_q <= newlen_q + n_d.len;
    end
    if (cmd.take) begin
      ne_q <= ne_sel;
    end
    if (cmd.out_load) begin
      status <= res_st_q;
      if (res_st_q == ffra_pkg::ST_OK) begin
        handle_index <= (kind_q == ffra_pkg::KIND_RELEASE) ? idx_q : res_index_q;
        handle_count <= cnt_q;
      end else begin
        handle_index <= '0;
        handle_count <= '0;
      end
    end
  end

  // Spare entries are the recycled stack plus table entries never used.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_q       <= NIL;
      tail_q       <= NIL;
      fresh_q      <= '0;
      rc_q         <= '0;
      pages_open_q <= '0;
    end else begin
      if (cmd.take) begin
        if (rc_q != '0) begin
          rc_q <= rc_q - 1'b1;
        end else begin
          fresh_q <= fresh_q + 1'b1;
        end
      end
      if (cmd.unlink) begin
        if (head_q == v_idx) begin
          head_q <= v_nxt;
        end
        if (tail_q == v_idx) begin
          tail_q <= v_prv;
        end
        if (rc_q < NIL) begin
          rc_q <= rc_q + 1'b1;
        end
      end
      if (cmd.link_last) begin
        tail_q <= ne_q;
        if (head_q == NIL) begin
          head_q <= ne_q;
        end
      end
      if (cmd.link_before && (head_q == e_q)) begin
        head_q <= ne_q;
      end
      if (cmd.open_page) begin
        pages_open_q <= pages_open_q + 1'b1;
      end
    end
  end

  always_comb begin
    sts.is_release = kind_q;
    sts.bad_cnt    = (cnt_q == '0) || (cnt_q > hs_q);
    sts.walk_ok    = (e_q < NIL) && (steps_q < NIL);
    sts.c_fits     = c_d.len >= cnt_q;
    sts.c_exact    = c_d.len == cnt_q;
    sts.pages_full = 32'(pages_open_q) >= MAX_PAGES;
    sts.need_entry = cnt_q < hs_q;
    sts.spare      = (rc_q != '0) || (fresh_q < NIL);
    sts.div_done   = div_done;
    sts.page_bad   = 32'(page) >= 32'(pages_open_q);
    sts.stop_bad   = stop > SW'(hs_q);
    sts.same_pg    = 32'(c_d.pg) == 32'(page);
    sts.adj_after  = (SW'(c_d.ofs) + SW'(c_d.len)) == SW'(begin_ofs);
    sts.stop_eq    = stop == SW'(c_d.ofs);
    sts.stop_lt    = stop < SW'(c_d.ofs);
    sts.n_valid    = c_nxt < NIL;
    sts.n_merge    = (32'(n_d.pg) == 32'(page)) &&
                     ((SW'(c_d.ofs) + SW'(newlen_q)) == SW'(n_d.ofs));
  end

`ifndef SYNTHESIS
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (head_q == NIL) == (tail_q == NIL))
    else $error("list head and tail disagree on an empty list");

  a_recycled: assert property (@(posedge clk) disable iff (rst)
    rc_q <= fresh_q)
    else $error("more recycled entries than entries ever used");

  a_pages: assert property (@(posedge clk) disable iff (rst)
    32'(pages_open_q) <= MAX_PAGES)
    else $error("open page count above the limit");

  a_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> ((rc_q != '0) || (fresh_q < NIL)))
    else $error("table entry taken with none spare");
`endif

endmodule
`default_nettype wire

@@ design/ffra_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer for allocate and release: walks the free list, decides, and
// issues table updates to the datapath.
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire ffra_pkg::ffra_sts_t sts,
  output ffra_pkg::ffra_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_A_FETCH, S_A_EVAL, S_A_IDX, S_UNLINK, S_A_NOFIT,
    S_A_LINK, S_A_MUL, S_A_OPEN, S_R_DIV, S_R_CHK, S_R_FETCH, S_R_EVAL,
    S_R_NFETCH, S_R_NEVAL, S_R_MERGE, S_R_WLEN, S_R_END, S_R_LLAST,
    S_R_LBEF, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.bad_cnt) begin
          cmd.st_wr  = 1'b1;
          cmd.st_val = ffra_pkg::ST_BAD_COUNT;
          state_next = S_FIN;
        end else if (sts.is_release) begin
          cmd.div_start = 1'b1;
          state_next    = S_R_DIV;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_A_FETCH;
        end
      end
      S_A_FETCH: begin
        if (sts.walk_ok) begin
          cmd.rd_cur = 1'b1;
          state_next = S_A_EVAL;
        end else begin
          state_next = S_A_NOFIT;
        end
      end
      S_A_EVAL: begin
        if (sts.c_fits) begin
          cmd.mul_cur = 1'b1;
          state_next  = S_A_IDX;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_A_FETCH;
        end
      end
      S_A_IDX: begin
        cmd.idx_load = 1'b1;
        cmd.idx_ofs  = 1'b1;
        if (sts.c_exact) begin
          state_next = S_UNLINK;
        end else begin
          cmd.trim   = 1'b1;
          state_next = S_FIN;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_FIN;
      end
      S_A_NOFIT: begin
        if (sts.pages_full) begin
          cmd.st_wr  = 1'b1;
          cmd.st_val = ffra_pkg::ST_NO_PAGE;
          state_next = S_FIN;
        end else if (!sts.need_entry) begin
          state_next = S_A_MUL;
        end else if (sts.spare) begin
          cmd.take   = 1'b1;
          state_next = S_A_LINK;
        end else begin
          cmd.st_wr  = 1'b1;
          cmd.st_val = ffra_pkg::ST_TABLE_FULL;
          state_next = S_FIN;
        end
      end
      S_A_LINK: begin
        cmd.link_last = 1'b1;
        state_next    = S_A_MUL;
      end
      S_A_MUL: begin
        cmd.mul_open = 1'b1;
        state_next   = S_A_OPEN;
      end
      S_A_OPEN: begin
        cmd.idx_load  = 1'b1;
        cmd.open_page = 1'b1;
        state_next    = S_FIN;
      end
      S_R_DIV: begin
        if (sts.div_done) begin
          state_next = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (sts.page_bad) begin
          cmd.st_wr  = 1'b1;
          cmd.st_val = ffra_pkg::ST_NO_PAGE;
          state_next = S_FIN;
        end else if (sts.stop_bad) begin
          cmd.st_wr  = 1'b1;
          cmd.st_val = ffra_pkg::ST_BAD_COUNT;
          state_next = S_FIN;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_R_FETCH;
        end
      end
      S_R_FETCH: begin
        if (sts.walk_ok) begin
          cmd.rd_cur = 1'b1;
          state_next = S_R_EVAL;
        end else begin
          state_next = S_R_END;
        end
      end
      S_R_EVAL: begin
        if (sts.same_pg && sts.adj_after) begin
          cmd.newlen_init = 1'b1;
          state_next      = sts.n_valid ? S_R_NFETCH : S_R_WLEN;
        end else if (sts.same_pg && sts.stop_eq) begin
          cmd.grow_front = 1'b1;
          state_next     = S_FIN;
        end else if (sts.same_pg && sts.stop_lt) begin
          if (sts.spare) begin
            cmd.take        = 1'b1;
            cmd.take_before = 1'b1;
            state_next      = S_R_LBEF;
          end else begin
            cmd.st_wr  = 1'b1;
            cmd.st_val = ffra_pkg::ST_TABLE_FULL;
            state_next = S_FIN;
          end
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_R_FETCH;
        end
      end
      S_R_NFETCH: begin
        cmd.rd_nb  = 1'b1;
        state_next = S_R_NEVAL;
      end
      S_R_NEVAL: begin
        if (sts.n_merge) begin
          cmd.newlen_add = 1'b1;
          state_next     = S_R_MERGE;
        end else begin
          state_next = S_R_WLEN;
        end
      end
      S_R_MERGE: begin
        cmd.unlink    = 1'b1;
        cmd.unlink_nb = 1'b1;
        state_next    = S_R_WLEN;
      end
      S_R_WLEN: begin
        cmd.wr_len = 1'b1;
        state_next = S_FIN;
      end
      S_R_END: begin
        if (sts.spare) begin
          cmd.take   = 1'b1;
          state_next = S_R_LLAST;
        end else begin
          cmd.st_wr  = 1'b1;
          cmd.st_val = ffra_pkg::ST_TABLE_FULL;
          state_next = S_FIN;
        end
      end
      S_R_LLAST: begin
        cmd.link_last = 1'b1;
        state_next    = S_FIN;
      end
      S_R_LBEF: begin
        cmd.link_before = 1'b1;
        state_next      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/first_fit_range_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator of contiguous slot ranges over pages opened on demand,
// with a coalescing free list.
// ----------------------------------------------------------------------------
// Usage: a request transaction on in_valid/in_ready carries kind, req_count
// and req_index; one response transaction on out_valid/out_ready returns
// handle_index, handle_count and status. One request is in service at a time.
// An allocate walks the free list, reading at most MAX_RANGES entries, and
// takes the first range that fits, unlinking it when it is used up, or else
// opens a new page. A release runs its checks and the bit-serial page/offset
// divider, walks the free list entry by entry and then finishes the update.
// The list walk through the single-read range table sets the rate, and the
// next request can be taken in the cycle after the response is loaded.
// The response register sits between the sides: a stalled receiver holds
// the finished response while the next request is taken and worked on; the
// block waits only when a second response is ready before the first is taken.
// Reset empties the free list, marks all range table entries spare, closes
// all pages and sets the page size register to 256. No clearing pass is
// needed. The page size is written over the APB port at address 0; the user
// must write it only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module first_fit_range_allocator #(
  parameter int MAX_PAGES  = 16,
  parameter int MAX_RANGES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       kind,
  input  wire logic [ffra_pkg::CNT_W-1:0] req_count,
  input  wire logic [ffra_pkg::IDX_W-1:0] req_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [ffra_pkg::IDX_W-1:0] handle_index,
  output logic      [ffra_pkg::CNT_W-1:0] handle_count,
  output logic      [ffra_pkg::ST_W-1:0]  status
);

  logic [ffra_pkg::HS_W-1:0] page_slots;
  logic [ffra_pkg::HS_W-1:0] hs_eff;
  ffra_pkg::ffra_cmd_t       cmd;
  ffra_pkg::ffra_sts_t       sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffra_pkg::REG_PAGE_SIZE) ? 32'(page_slots) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_slots <= ffra_pkg::HS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ffra_pkg::REG_PAGE_SIZE)) begin
      page_slots <= pwdata[ffra_pkg::HS_W-1:0];
    end
  end

  // Page size in use: zero acts as one, large values saturate.
  always_comb begin
    if (page_slots == '0) begin
      hs_eff = ffra_pkg::HS_W'(1);
    end else if (32'(page_slots) > ffra_pkg::MAX_PAGE_SLOTS) begin
      hs_eff = ffra_pkg::HS_W'(ffra_pkg::MAX_PAGE_SLOTS);
    end else begin
      hs_eff = page_slots;
    end
  end

  ffra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffra_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .hs_eff       (hs_eff),
    .kind         (kind),
    .req_count    (req_count),
    .req_index    (req_index),
    .handle_index (handle_index),
    .handle_count (handle_count),
    .status       (status)
  );

endmodule
`default_nettype wire
